/* hdl/assert_macros.svh */
// Assertion macros for the list block checker.
// Used by files that hold concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list block: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list block: next-cycle check failed");

`endif

/* hdl/clad_pkg.sv */
// Shared types and constants for the compacting list block.
// No dependencies; used by every module of the block.
`default_nettype none

package clad_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int CNT_W        = 7;
    localparam int OP_W         = 2;
    localparam int ST_W         = 2;
    localparam int IN_W         = 40;
    localparam int OUT_W        = 48;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic    append;
        logic    remove;
        logic    rotate;
        logic    dump_start;
        logic    out_load;
        logic    out_from_cell;
        logic    out_last;
        t_status out_status;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_ok;
        logic dump_end;
    } t_dp_stat;

endpackage

`default_nettype wire

/* hdl/clad_dpath.sv */
// Datapath: row of entry cells, entry count, dump index and output register.
// Depends on clad_pkg.
`default_nettype none

module clad_dpath #(
    parameter int CAPACITY = clad_pkg::CAPACITY_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire clad_pkg::t_dp_cmd                   i_cmd,
    input  wire logic signed [clad_pkg::DATA_W-1:0]  i_value,
    input  wire logic        [clad_pkg::POS_W-1:0]   i_pos,
    output clad_pkg::t_dp_stat                       o_stat,
    output logic             [clad_pkg::ST_W-1:0]    o_status,
    output logic signed      [clad_pkg::DATA_W-1:0]  o_value,
    output logic             [clad_pkg::POS_W-1:0]   o_index,
    output logic             [clad_pkg::CNT_W-1:0]   o_count,
    output logic                                     o_last
);

    localparam int CW = clad_pkg::CNT_W;
    localparam int PW = clad_pkg::POS_W;
    localparam int DW = clad_pkg::DATA_W;

    logic signed [DW-1:0] r_cell [CAPACITY];
    logic [CW-1:0]        r_count, n_count;
    logic [PW-1:0]        r_dump_idx;

    logic [clad_pkg::ST_W-1:0] r_status;
    logic signed [DW-1:0]      r_value;
    logic [PW-1:0]             r_index;
    logic [CW-1:0]             r_out_count;
    logic                      r_last;

    // Cell row: append writes at the tail, delete shifts down from the
    // position, rotate moves every held entry down by one and wraps
    // the head round to the tail.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [DW-1:0] w_up;
        logic                 w_below_tail;
        logic                 w_is_tail;
        logic                 w_at_count;

        if (gi + 1 < CAPACITY) begin : g_up
            assign w_up = r_cell[gi+1];
        end else begin : g_wrap
            assign w_up = r_cell[0];
        end

        assign w_below_tail = (CW'(gi + 1) < r_count);
        assign w_is_tail    = (CW'(gi + 1) == r_count);
        assign w_at_count   = (CW'(gi) == r_count);

        always_ff @(posedge i_clk) begin
            if (i_cmd.append && w_at_count) begin
                r_cell[gi] <= i_value;
            end else if (i_cmd.remove && (CW'(gi) >= CW'(i_pos)) && w_below_tail) begin
                r_cell[gi] <= w_up;
            end else if (i_cmd.rotate) begin
                if (w_below_tail) begin
                    r_cell[gi] <= w_up;
                end else if (w_is_tail) begin
                    r_cell[gi] <= r_cell[0];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.remove) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dump_idx <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.dump_start) begin
                r_dump_idx <= '0;
            end else if (i_cmd.rotate) begin
                r_dump_idx <= r_dump_idx + PW'(1);
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status    <= i_cmd.out_status;
            r_value     <= i_cmd.out_from_cell ? r_cell[0] : '0;
            r_index     <= i_cmd.out_from_cell ? r_dump_idx : '0;
            r_out_count <= n_count;
            r_last      <= i_cmd.out_last;
        end
    end

    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (r_count >= CW'(CAPACITY));
    assign o_stat.pos_ok   = (CW'(i_pos) < r_count);
    assign o_stat.dump_end = ((CW'(r_dump_idx) + CW'(1)) == r_count);

    assign o_status = r_status;
    assign o_value  = r_value;
    assign o_index  = r_index;
    assign o_count  = r_out_count;
    assign o_last   = r_last;

endmodule

`default_nettype wire

/* hdl/clad_ctrl.sv */
// Controller: input/output handshake and the dump sequencer.
// Depends on clad_pkg.
`default_nettype none

module clad_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [clad_pkg::OP_W-1:0]   i_opcode,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire clad_pkg::t_dp_stat          i_stat,
    output clad_pkg::t_dp_cmd                o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;
    clad_pkg::t_opcode w_op;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = clad_pkg::t_opcode'(i_opcode);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.out_status = clad_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                o_cmd.out_last = 1'b1;
                if (w_accept) begin
                    case (w_op)
                        clad_pkg::OP_APPEND: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = clad_pkg::ST_FULL;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        clad_pkg::OP_DELETE: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.out_status = clad_pkg::ST_EMPTY;
                            end else if (!i_stat.pos_ok) begin
                                o_cmd.out_status = clad_pkg::ST_BADPOS;
                            end else begin
                                o_cmd.remove = 1'b1;
                            end
                        end
                        clad_pkg::OP_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = clad_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_from_cell = 1'b1;
                    o_cmd.out_last      = i_stat.dump_end;
                    o_cmd.rotate        = 1'b1;
                    if (i_stat.dump_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/compacting_list_append_delete.sv */
// Top level of the compacting list block: controller plus datapath.
// Depends on clad_pkg, clad_ctrl and clad_dpath.
//
// Use:
//   Slave stream carries commands: opcode 0 appends item_value at the tail,
//   1 deletes the entry at position and closes the gap, 2 dumps the list.
//   Opcode 3 is swallowed without a result.
//   Master stream carries results; tlast marks the final beat of a command.
// Result timing:
//   The result of an append or delete (and every error result) sits in the
//   output register the cycle after the command beat, and the next command
//   can be taken in that same cycle if the output is free or being drained.
//   A non-empty dump enters the dump state and then loads one entry per
//   beat while the output is free; entries leave cell 0 of the cell row,
//   which rotates by one per beat and is back in order after the last one.
//   Commands are held off until the last dump beat is loaded.
// Reset: i_rst_n (synchronous, active low) empties the list and drops the
//   output valid. Entry contents are not cleared.
// Back-pressure: while a beat waits with i_m_tready low the beat holds and the
//   block neither takes commands nor advances a dump.
`default_nettype none

module compacting_list_append_delete #(
    parameter int CAPACITY = clad_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // [1:0] opcode, [33:2] item_value, [39:34] position
    input  wire logic [clad_pkg::IN_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // [1:0] status, [33:2] entry_value, [39:34] entry_index,
    // [46:40] count_after, [47] zero
    output logic      [clad_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast
);

    clad_pkg::t_dp_cmd  w_cmd;
    clad_pkg::t_dp_stat w_stat;

    logic [clad_pkg::ST_W-1:0]          w_status;
    logic signed [clad_pkg::DATA_W-1:0] w_value;
    logic [clad_pkg::POS_W-1:0]         w_index;
    logic [clad_pkg::CNT_W-1:0]         w_count;

    clad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_opcode   (i_s_tdata[1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    clad_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_value  (i_s_tdata[33:2]),
        .i_pos    (i_s_tdata[39:34]),
        .o_stat   (w_stat),
        .o_status (w_status),
        .o_value  (w_value),
        .o_index  (w_index),
        .o_count  (w_count),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_count, w_index, w_value, w_status};

endmodule

`default_nettype wire

/* hdl/clad_checker.sv */
// Port-level checks on the compacting list block, bound to its top level.
// Depends on clad_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module clad_checker #(
    parameter int CAPACITY = clad_pkg::CAPACITY_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_s_tready,
    input wire logic                       o_m_tvalid,
    input wire logic                       i_m_tready,
    input wire logic [clad_pkg::OUT_W-1:0] o_m_tdata,
    input wire logic                       o_m_tlast
);

    logic [clad_pkg::ST_W-1:0]  w_status;
    logic [clad_pkg::CNT_W-1:0] w_count;

    assign w_status = o_m_tdata[1:0];
    assign w_count  = o_m_tdata[46:40];

    // A stalled beat holds
    `CLAD_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // Never more entries than the list can hold
    `CLAD_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, o_m_tvalid, w_count <= clad_pkg::CNT_W'(CAPACITY))

    // Every error result is a single, final beat
    `CLAD_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_m_tvalid && (w_status != clad_pkg::ST_OK), o_m_tlast)

    // An empty result reports an empty list and no entry
    `CLAD_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_m_tvalid && (w_status == clad_pkg::ST_EMPTY), (w_count == '0) && (o_m_tdata[39:2] == '0))

    // No command is taken in the middle of a dump
    `CLAD_ASSERT_IMP(a_dump_block, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, !o_s_tready)

endmodule

bind compacting_list_append_delete clad_checker #(
    .CAPACITY (CAPACITY)
) u_clad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
